### rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants for the biquad filter section: widths,
// register indexes and the control word from sequencer to datapath.
// ----------------------------------------------------------------------------
package bfs_pkg;

	// default sample and coefficient widths
	localparam int BFS_SAMPLE_WIDTH = 24;
	localparam int BFS_COEF_WIDTH   = 32;

	// delay state width, fraction bits match the sample format
	localparam int STATE_WIDTH = 48;

	// coefficients carry four integer bits (sign included)
	localparam int COEF_INT_BITS = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_2 = 3'd4;

	// operand pair fed to the shared multiplier
	typedef enum logic [2:0] {
		OP_B0X,
		OP_B1X,
		OP_B2X,
		OP_A1Y,
		OP_A2Y
	} mul_op_t;

	// what the shared adder does with the rounded product
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_Y,
		ACC_D1_INIT,
		ACC_D2_INIT,
		ACC_D1_SUB,
		ACC_D2_SUB
	} acc_op_t;

	// control word from the sequencer
	typedef struct packed {
		logic    mul_en;
		mul_op_t mul_op;
		acc_op_t acc_op;
		logic    finish;
	} ctrl_t;

endpackage

### rtl/biquad_filter_section_core.sv
// ----------------------------------------------------------------------------
// biquad_filter_section_core
// One second-order IIR section, transposed direct form II, Q1.23 samples,
// Q3.28 coefficients, 48-bit delay state, rounded products, saturated output.
// An accepted request steps the sequencer through M0 to M4, A4 and DONE; the
// result then goes to the output register. A new request is taken only in idle,
// as the five products share one multiplier and adder; a stalled output holds DONE.
// A finished result may wait in the output register while the next request
// is taken. Reset clears coefficients, delay state and all valid flags.
// ----------------------------------------------------------------------------
module biquad_filter_section_core
	import bfs_pkg::*;
#(
	parameter int SAMPLE_WIDTH = BFS_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = BFS_COEF_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	localparam int ACC_W = STATE_WIDTH + 2;

	logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [STATE_WIDTH-1:0]  d1_q, d2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q, y_q;
	logic                           clip_q;
	logic signed [ACC_W-1:0]        acc1_q, acc2_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic                           busy, accept, out_free;
	ctrl_t                          ctrl;
	logic signed [COEF_WIDTH-1:0]   mul_coef;
	logic signed [SAMPLE_WIDTH-1:0] mul_opnd;
	logic signed [STATE_WIDTH-1:0]  rounded;
	logic signed [ACC_W-1:0]        add_a, add_b, add_sum;
	logic                           add_sub;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           y_clip;
	logic signed [STATE_WIDTH-1:0]  d1_sat, d2_sat;

	assign accept   = in_valid && !in_stall;
	assign in_stall = busy;
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	bfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FEED_COEF_0: b0_q <= cfg_data;
				REG_FEED_COEF_1: b1_q <= cfg_data;
				REG_FEED_COEF_2: b2_q <= cfg_data;
				REG_BACK_COEF_1: a1_q <= cfg_data;
				REG_BACK_COEF_2: a2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		unique case (ctrl.mul_op)
			OP_B0X: begin mul_coef = b0_q; mul_opnd = x_q; end
			OP_B1X: begin mul_coef = b1_q; mul_opnd = x_q; end
			OP_B2X: begin mul_coef = b2_q; mul_opnd = x_q; end
			OP_A1Y: begin mul_coef = a1_q; mul_opnd = y_q; end
			OP_A2Y: begin mul_coef = a2_q; mul_opnd = y_q; end
			default: begin mul_coef = b0_q; mul_opnd = x_q; end
		endcase
	end

	// shared multiplier with rounding
	bfs_mul #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_mul (
		.clk     (clk),
		.en      (ctrl.mul_en),
		.coef    (mul_coef),
		.opnd    (mul_opnd),
		.rounded (rounded)
	);

	// shared adder operand select
	always_comb begin
		add_a   = '0;
		add_sub = 1'b0;
		unique case (ctrl.acc_op)
			ACC_NONE:    add_a = '0;
			ACC_Y:       add_a = ACC_W'(d1_q);
			ACC_D1_INIT: add_a = ACC_W'(d2_q);
			ACC_D2_INIT: add_a = '0;
			ACC_D1_SUB:  begin add_a = acc1_q; add_sub = 1'b1; end
			ACC_D2_SUB:  begin add_a = acc2_q; add_sub = 1'b1; end
			default:     add_a = '0;
		endcase
	end

	assign add_b   = add_sub ? -ACC_W'(rounded) : ACC_W'(rounded);
	assign add_sum = add_a + add_b;

	// output saturation to the sample range
	always_comb begin
		y_clip = !((&add_sum[ACC_W-1:SAMPLE_WIDTH-1]) || !(|add_sum[ACC_W-1:SAMPLE_WIDTH-1]));
		if (!y_clip) begin
			y_sat = add_sum[SAMPLE_WIDTH-1:0];
		end else if (add_sum[ACC_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	// state saturation to 48 bits
	always_comb begin
		if ((&acc1_q[ACC_W-1:STATE_WIDTH-1]) || !(|acc1_q[ACC_W-1:STATE_WIDTH-1])) begin
			d1_sat = acc1_q[STATE_WIDTH-1:0];
		end else if (acc1_q[ACC_W-1]) begin
			d1_sat = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		end else begin
			d1_sat = {1'b0, {(STATE_WIDTH-1){1'b1}}};
		end
		if ((&acc2_q[ACC_W-1:STATE_WIDTH-1]) || !(|acc2_q[ACC_W-1:STATE_WIDTH-1])) begin
			d2_sat = acc2_q[STATE_WIDTH-1:0];
		end else if (acc2_q[ACC_W-1]) begin
			d2_sat = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		end else begin
			d2_sat = {1'b0, {(STATE_WIDTH-1){1'b1}}};
		end
	end

	// working registers: sample, output and accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
		unique case (ctrl.acc_op)
			ACC_Y: begin
				y_q    <= y_sat;
				clip_q <= y_clip;
			end
			ACC_D1_INIT, ACC_D1_SUB: acc1_q <= add_sum;
			ACC_D2_INIT, ACC_D2_SUB: acc2_q <= add_sum;
			default: begin
			end
		endcase
	end

	// delay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctrl.finish) begin
			d1_q <= d1_sat;
			d2_q <= d2_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled while a request is in progress");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> out_valid)
		else $error("finished result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");

endmodule

### rtl/bfs_mul.sv
// ----------------------------------------------------------------------------
// bfs_mul
// Shared coefficient by sample multiplier with registered product, then
// round to nearest (half up) into the delay state format.
// ----------------------------------------------------------------------------
module bfs_mul
	import bfs_pkg::*;
#(
	parameter int SAMPLE_WIDTH = BFS_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = BFS_COEF_WIDTH
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COEF_WIDTH-1:0]  coef,
	input  logic signed [SAMPLE_WIDTH-1:0] opnd,
	output logic signed [STATE_WIDTH-1:0] rounded
);

	localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int FRAC   = COEF_WIDTH - COEF_INT_BITS;
	localparam int RND_W  = PROD_W - FRAC;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC - 1);

	logic signed [PROD_W-1:0] prod_q;
	logic        [PROD_W-1:0] rnd_sum;

	// product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= $signed(coef) * $signed(opnd);
		end
	end

	// add half an lsb, drop fraction bits, sign extend (at most 28 bits, fits the state)
	assign rnd_sum = prod_q + HALF;
	assign rounded = {{(STATE_WIDTH - RND_W){rnd_sum[PROD_W-1]}}, rnd_sum[PROD_W-1:FRAC]};

endmodule

### rtl/bfs_seq.sv
// ----------------------------------------------------------------------------
// bfs_seq
// Sequencer: steps the shared multiplier and adder through the five
// products of one sample and hands the result to the output register.
// ----------------------------------------------------------------------------
module bfs_seq
	import bfs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  out_free,
	output logic  busy,
	output ctrl_t ctrl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_A4,
		S_DONE
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_M0;
				S_M0:   state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_M3;
				S_M3:   state_q <= S_M4;
				S_M4:   state_q <= S_A4;
				S_A4:   state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// control decode: multiply step k while accumulating step k-1
	always_comb begin
		ctrl.mul_en = 1'b0;
		ctrl.mul_op = OP_B0X;
		ctrl.acc_op = ACC_NONE;
		ctrl.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_M0: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_B0X;
			end
			S_M1: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_B1X;
				ctrl.acc_op = ACC_Y;
			end
			S_M2: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_B2X;
				ctrl.acc_op = ACC_D1_INIT;
			end
			S_M3: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_A1Y;
				ctrl.acc_op = ACC_D2_INIT;
			end
			S_M4: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_A2Y;
				ctrl.acc_op = ACC_D1_SUB;
			end
			S_A4: begin
				ctrl.acc_op = ACC_D2_SUB;
			end
			S_DONE: begin
				ctrl.finish = out_free;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// a request is only taken when idle, and a busy pass always ends in done
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_M0)
		else $error("sequencer did not start on request");
	a_done_after_a4: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A4 |=> state_q == S_DONE)
		else $error("sequencer skipped the done step");

endmodule

### sim/tb_biquad_filter_section_core.sv
// ----------------------------------------------------------------------------
// tb_biquad_filter_section_core
// Self-checking bench for the biquad filter section. A bit-exact fixed-point
// filter model runs next to the block: each accepted input request updates
// the model's delay state and queues the filtered sample it must produce.
// Every output request is checked against the oldest queued sample, under
// random bursts, output stalls, a long output hold-off and many coefficient
// settings.
// ----------------------------------------------------------------------------
module tb_biquad_filter_section_core;
	import bfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW        = BFS_SAMPLE_WIDTH;
	localparam int CW        = BFS_COEF_WIDTH;
	localparam int COEF_FRAC = CW - COEF_INT_BITS;
	localparam int DRAIN     = 12;
	localparam int HOLD_LEN  = 300;
	localparam int WAIT_MAX  = 20000;

	// Q3.28 coefficient values
	localparam logic signed [CW-1:0] COEF_ONE  = 32'sd268435456;
	localparam logic signed [CW-1:0] COEF_HALF = 32'sd134217728;
	localparam logic signed [CW-1:0] COEF_MAX  = 32'sh7FFFFFFF;
	localparam logic signed [CW-1:0] COEF_MIN  = 32'sh80000000;
	localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 clip;
	} filtered_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]        cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic                 clipped;

	// filter model: coefficients and delay line
	logic signed [CW-1:0] coef_model [0:4];
	longint               delay_one;
	longint               delay_two;

	filtered_t expected_q [$];
	int        fail_count   = 0;
	int        sent_count   = 0;
	int        checked      = 0;
	int        clip_count   = 0;
	int        held_cycles  = 0;
	int        settings     = 0;
	int        stall_pct    = 0;
	bit        hold_request = 1'b0;

	biquad_filter_section_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// clamp to a signed range of the given width
	function automatic longint saturate(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// coefficient times sample, rounded half up into the state format
	function automatic longint round_product(logic signed [CW-1:0] c, longint v);
		longint p;
		p = longint'(c) * v;
		return saturate((p + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, STATE_WIDTH);
	endfunction

	// one transposed direct form II step, updates the delay line
	function automatic filtered_t filter_sample(logic signed [SW-1:0] x);
		longint    xs;
		longint    y_raw;
		longint    y;
		longint    d1;
		longint    d2;
		filtered_t r;
		xs    = longint'(x);
		y_raw = round_product(coef_model[REG_FEED_COEF_0], xs) + delay_one;
		y     = saturate(y_raw, SW);
		d1    = round_product(coef_model[REG_FEED_COEF_1], xs)
			- round_product(coef_model[REG_BACK_COEF_1], y) + delay_two;
		d2    = round_product(coef_model[REG_FEED_COEF_2], xs)
			- round_product(coef_model[REG_BACK_COEF_2], y);
		delay_one = saturate(d1, STATE_WIDTH);
		delay_two = saturate(d2, STATE_WIDTH);
		r.sample  = y[SW-1:0];
		r.clip    = (y != y_raw);
		return r;
	endfunction

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return SW'($urandom_range(0, 1023)) - SW'(512);
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic signed [CW-1:0] random_coef();
		case ($urandom_range(0, 7))
			0:       return COEF_MAX;
			1:       return COEF_MIN;
			2:       return '0;
			default: return CW'($urandom);
		endcase
	endfunction

	// within plus or minus one, keeps the feedback mostly tame
	function automatic logic signed [CW-1:0] modest_coef();
		return CW'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
	endfunction

	// offer one input request and hold it until accepted
	task automatic send_sample(logic signed [SW-1:0] x);
		in_valid  <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(filter_sample(x));
		sent_count++;
	endtask

	// stream random samples, optionally in bursts with gaps between
	task automatic run_samples(int count, bit gaps);
		int burst;
		burst = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			send_sample(random_sample());
			burst--;
			if (gaps && burst == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst = $urandom_range(1, 24);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// let every expected sample arrive, then a little longer
	task automatic wait_idle();
		int spent;
		spent = 0;
		while (expected_q.size() != 0 && spent < WAIT_MAX) begin
			@(posedge clk);
			spent++;
		end
		if (expected_q.size() != 0) begin
			$display("%0t drain stuck: %0d samples still expected", $time, expected_q.size());
			fail_count++;
		end
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [CW-1:0] val);
		cfg_wr    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx <= REG_BACK_COEF_2) coef_model[idx] = val;
	endtask

	task automatic load_coefs(logic signed [CW-1:0] b0, logic signed [CW-1:0] b1,
		logic signed [CW-1:0] b2, logic signed [CW-1:0] a1, logic signed [CW-1:0] a2);
		wait_idle();
		write_reg(REG_FEED_COEF_0, b0);
		write_reg(REG_FEED_COEF_1, b1);
		write_reg(REG_FEED_COEF_2, b2);
		write_reg(REG_BACK_COEF_1, a1);
		write_reg(REG_BACK_COEF_2, a2);
		cfg_wr <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	task automatic load_lowpass();
		load_coefs(32'sd18119393, 32'sd36238786, 32'sd18119393,
			-32'sd306821727, 32'sd110810157);
	endtask

	// coefficients are zero after reset, so everything filters to silence
	task automatic test_reset_state();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// unity feedforward, sample fields at their extremes and bit patterns
	task automatic test_passthrough();
		load_coefs(COEF_ONE, '0, '0, '0, '0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample(-24'sd1);
		send_sample(24'sh555555);
		send_sample(24'shAAAAAA);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// writes past the last register must not disturb the coefficients
	task automatic test_unused_index();
		logic [CFG_IDX_W-1:0] idx;
		wait_idle();
		idx = REG_BACK_COEF_2;
		while (idx != '1) begin
			idx++;
			write_reg(idx, COEF_MAX);
		end
		cfg_wr <= 1'b0;
		@(posedge clk);
		send_sample(24'sd12345);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// halfway products round toward plus infinity
	task automatic test_rounding();
		load_coefs(COEF_HALF, '0, '0, '0, '0);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		send_sample(24'sd3);
		send_sample(-24'sd3);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// largest gains drive the output into both rails
	task automatic test_saturation();
		load_coefs(COEF_MAX, '0, '0, '0, '0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		in_valid <= 1'b0;
		@(posedge clk);
		load_coefs(COEF_MIN, '0, '0, '0, '0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// impulse through extreme feedforward and feedback coefficients
	task automatic test_feedback();
		load_coefs(COEF_ONE, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
		send_sample(SAMPLE_MAX);
		send_sample('0);
		send_sample('0);
		send_sample('0);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// realistic lowpass and bandpass sections
	task automatic test_stable_filters();
		stall_pct = 0;
		load_lowpass();
		run_samples(100, 1'b0);
		stall_pct = 30;
		load_coefs(32'sd26843546, '0, -32'sd26843546, -32'sd429496730, 32'sd214748365);
		run_samples(100, 1'b1);
	endtask

	task automatic test_random_coefs();
		stall_pct = 50;
		for (int k = 0; k < 6; k++) begin
			load_coefs(random_coef(), random_coef(), random_coef(),
				random_coef(), random_coef());
			run_samples(40, 1'b1);
		end
	endtask

	task automatic test_coef_extremes();
		stall_pct = 20;
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		run_samples(50, 1'b1);
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		run_samples(50, 1'b1);
	endtask

	task automatic test_modest_coefs();
		for (int k = 0; k < 4; k++) begin
			stall_pct = (k % 2) ? 70 : 0;
			load_coefs(modest_coef(), modest_coef(), modest_coef(),
				modest_coef(), modest_coef());
			run_samples(40, 1'b1);
		end
	endtask

	// long output hold-off while requests keep coming
	task automatic test_backpressure();
		stall_pct = 10;
		load_lowpass();
		hold_request = 1'b1;
		run_samples(80, 1'b0);
	endtask

	// output stall pattern: random runs, plus a long hold when asked
	initial begin
		int run;
		int hold_left;
		bit stalled;
		run       = 0;
		hold_left = 0;
		stalled   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_LEN;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run == 0) begin
					stalled = ($urandom_range(0, 99) < stall_pct);
					run     = $urandom_range(1, 8);
				end
				run--;
				out_stall <= stalled;
			end
		end
	end

	// check each output request against the oldest expected sample
	always @(posedge clk) begin
		filtered_t want;
		if (arst_n && in_valid && in_stall) held_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected output: sample_out %0d clipped %0b",
					$time, sample_out, clipped);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (want.clip) clip_count++;
				if (sample_out !== want.sample) begin
					$display("%0t sample_out mismatch: expected %0d, actual %0d",
						$time, want.sample, sample_out);
					fail_count++;
				end
				if (clipped !== want.clip) begin
					$display("%0t clipped mismatch: expected %0b, actual %0b",
						$time, want.clip, clipped);
					fail_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 5; i++) coef_model[i] = '0;
		delay_one = 0;
		delay_two = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_passthrough();
		test_unused_index();
		test_rounding();
		test_saturation();
		test_feedback();
		test_stable_filters();
		test_random_coefs();
		test_coef_extremes();
		test_modest_coefs();
		test_backpressure();
		wait_idle();

		$display("%0d samples sent, %0d outputs checked over %0d coefficient sets",
			sent_count, checked, settings);
		$display("%0d outputs clipped, input held back for %0d cycles",
			clip_count, held_cycles);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### biquad_filter_section_core.f
rtl/bfs_pkg.sv
rtl/bfs_mul.sv
rtl/bfs_seq.sv
rtl/biquad_filter_section_core.sv
sim/tb_biquad_filter_section_core.sv
